### rtl/core/bws_pkg.sv
// shared constants, types and helpers for the wheel speed controller
`default_nettype none

package bws_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int SLOT_W      = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int NUM_WEIGHTS = 8;

  localparam int IDX_W    = 3;
  localparam int RANGE_W  = 16;
  localparam int SPEED_W  = 16;
  localparam int WEIGHT_W = 8;
  localparam int PACKED_W = NUM_WEIGHTS * WEIGHT_W;
  localparam int CFG_W    = PACKED_W;
  localparam int CFG_IDX_W = 3;

  localparam int S_DATA_W = ((IDX_W + RANGE_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((2 * SPEED_W + RANGE_W + 7) / 8) * 8;

  localparam int ACT_W    = 17;
  localparam int MUL_A_W  = 34;
  localparam int MUL_B_W  = 17;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int AV_W     = 33;
  localparam int ACC_W    = 48;
  localparam int FRAC_DROP = 20;
  localparam int RND_W    = ACC_W - FRAC_DROP;

  localparam logic [RANGE_W-1:0] RANGE_FLOOR = 16'd82;
  localparam int                 ACT_ONE     = 65536;

  localparam logic [15:0] BASE_SPEED_RST = 16'd4096;
  localparam logic [15:0] FLOOR_RST      = 16'h8000;
  localparam logic [15:0] CEILING_RST    = 16'h7fff;
  localparam logic [15:0] MAX_RANGE_RST  = 16'd4096;
  localparam logic [15:0] FULL_DIST_RST  = 16'd410;
  localparam logic [15:0] INV_SPAN_RST   = 16'd4551;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_W    = 3'd0,
    REG_RIGHT_W   = 3'd1,
    REG_BASE      = 3'd2,
    REG_FLOOR     = 3'd3,
    REG_CEILING   = 3'd4,
    REG_MAX_RANGE = 3'd5,
    REG_FULL_DIST = 3'd6,
    REG_INV_SPAN  = 3'd7
  } bws_reg_t;

  typedef struct packed {
    logic              accept;
    logic              mul_t;
    logic              mul_av;
    logic              mul_l;
    logic              mul_r;
    logic [SLOT_W-1:0] slot;
    logic              load_out;
  } bws_cmd_t;

  function automatic logic signed [WEIGHT_W-1:0] weight_of(logic [PACKED_W-1:0] p,
                                                           int unsigned k);
    logic signed [WEIGHT_W-1:0] w;
    w = '0;
    for (int j = 0; j < NUM_WEIGHTS; j++) begin
      if (k == j) w = p[WEIGHT_W*j +: WEIGHT_W];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bws_ctrl.sv
// sequencer: slot walk, multiplier phases and output beat handshake
`default_nettype none

module bws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output bws_pkg::bws_cmd_t cmd
);
  import bws_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_T     = 7'b0000010,
    ST_AV    = 7'b0000100,
    ST_L     = 7'b0001000,
    ST_R     = 7'b0010000,
    ST_FLUSH = 7'b0100000,
    ST_DONE  = 7'b1000000
  } bws_state_t;

  bws_state_t        state, state_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic              out_valid, out_valid_next;
  logic              last_slot;
  logic              out_free;

  assign last_slot = (slot == SLOT_W'(NUM_SENSORS - 1));
  assign out_free  = !out_valid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = out_valid;

  always_comb begin
    state_next     = state;
    slot_next      = slot;
    out_valid_next = out_valid && !m_tready;
    cmd            = '0;
    cmd.slot       = slot;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          slot_next  = '0;
          state_next = ST_T;
        end
      end
      ST_T: begin
        cmd.mul_t  = 1'b1;
        state_next = ST_AV;
      end
      ST_AV: begin
        cmd.mul_av = 1'b1;
        state_next = ST_L;
      end
      ST_L: begin
        cmd.mul_l  = 1'b1;
        state_next = ST_R;
      end
      ST_R: begin
        cmd.mul_r = 1'b1;
        if (last_slot) begin
          state_next = ST_FLUSH;
        end else begin
          slot_next  = slot + 1'b1;
          state_next = ST_T;
        end
      end
      ST_FLUSH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      slot      <= slot_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bws_datapath.sv
// registers, range slots, shared multiplier, accumulators and output beat
`default_nettype none

module bws_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bws_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         action,
  input  logic [bws_pkg::IDX_W-1:0]    sensor_index,
  input  logic [bws_pkg::RANGE_W-1:0]  range_reading,
  input  bws_pkg::bws_cmd_t            cmd,
  output logic [bws_pkg::M_DATA_W-1:0] m_tdata
);
  import bws_pkg::*;

  logic [PACKED_W-1:0]       left_w, right_w;
  logic [15:0]               base_speed;
  logic signed [SPEED_W-1:0] speed_floor, speed_ceiling;
  logic [RANGE_W-1:0]        range_cap, full_dist;
  logic [15:0]               inv_span;

  logic [RANGE_W-1:0]        ranges [NUM_SENSORS];
  logic [RANGE_W-1:0]        cur_r, clamp_lo, clamp_r, e_val;
  logic                      act_zero;
  logic [32:0]               t_full;
  logic [24:0]               t_val;
  logic [ACT_W-1:0]          act;
  logic signed [WEIGHT_W-1:0] wl, wr;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [AV_W-1:0]           av;
  logic signed [ACC_W-1:0]   sum_l, sum_r;
  logic                      r_pend;
  logic [RANGE_W-1:0]        nearest;
  logic signed [SPEED_W-1:0] out_left, out_right;
  logic [RANGE_W-1:0]        out_nearest;

  function automatic logic signed [SPEED_W-1:0] finish(logic signed [ACC_W-1:0] s,
                                                       logic signed [SPEED_W-1:0] lo,
                                                       logic signed [SPEED_W-1:0] hi);
    logic signed [ACC_W-1:0] rnd;
    logic signed [RND_W-1:0] v;
    rnd = s + $signed(ACC_W'(1) << (FRAC_DROP - 1));
    v   = rnd[ACC_W-1:FRAC_DROP];
    if (v < $signed({{(RND_W-SPEED_W){lo[SPEED_W-1]}}, lo})) begin
      v = {{(RND_W-SPEED_W){lo[SPEED_W-1]}}, lo};
    end
    if (v > $signed({{(RND_W-SPEED_W){hi[SPEED_W-1]}}, hi})) begin
      v = {{(RND_W-SPEED_W){hi[SPEED_W-1]}}, hi};
    end
    return v[SPEED_W-1:0];
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_w        <= '0;
      right_w       <= '0;
      base_speed    <= BASE_SPEED_RST;
      speed_floor   <= FLOOR_RST;
      speed_ceiling <= CEILING_RST;
      range_cap     <= MAX_RANGE_RST;
      full_dist     <= FULL_DIST_RST;
      inv_span      <= INV_SPAN_RST;
    end else if (cfg_we) begin
      case (bws_reg_t'(cfg_index))
        REG_LEFT_W:    left_w        <= cfg_data;
        REG_RIGHT_W:   right_w       <= cfg_data;
        REG_BASE:      base_speed    <= cfg_data[15:0];
        REG_FLOOR:     speed_floor   <= cfg_data[15:0];
        REG_CEILING:   speed_ceiling <= cfg_data[15:0];
        REG_MAX_RANGE: range_cap     <= cfg_data[15:0];
        REG_FULL_DIST: full_dist     <= cfg_data[15:0];
        REG_INV_SPAN:  inv_span      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // reading clamp and slot store
  always_comb begin
    clamp_lo = (range_reading < RANGE_FLOOR) ? RANGE_FLOOR : range_reading;
    clamp_r  = (clamp_lo > range_cap) ? range_cap : clamp_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SENSORS; i++) ranges[i] <= MAX_RANGE_RST;
    end else if (cmd.accept) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (action) begin
          ranges[i] <= range_cap;
        end else if (int'(sensor_index) == i) begin
          ranges[i] <= clamp_r;
        end
      end
    end
  end

  // per-slot arithmetic
  always_comb begin
    cur_r  = ranges[cmd.slot];
    e_val  = ((cur_r < full_dist) ? full_dist : cur_r) - full_dist;
    t_full = {1'b0, prod[31:0]} + 33'd128;
    t_val  = t_full[32:8];
    if (act_zero || t_val >= 25'(ACT_ONE)) begin
      act = '0;
    end else begin
      act = ACT_W'(ACT_ONE) - t_val[ACT_W-1:0];
    end
    wl = weight_of(left_w, int'(cmd.slot));
    wr = weight_of(right_w, int'(cmd.slot));
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_t) begin
      mul_a = {{(MUL_A_W-RANGE_W){1'b0}}, e_val};
      mul_b = {1'b0, inv_span};
    end else if (cmd.mul_av) begin
      mul_a = {{(MUL_A_W-ACT_W){1'b0}}, act};
      mul_b = {1'b0, base_speed};
    end else if (cmd.mul_l) begin
      mul_a = {1'b0, prod[AV_W-1:0]};
      mul_b = {{(MUL_B_W-WEIGHT_W){wl[WEIGHT_W-1]}}, wl};
    end else if (cmd.mul_r) begin
      mul_a = {1'b0, av};
      mul_b = {{(MUL_B_W-WEIGHT_W){wr[WEIGHT_W-1]}}, wr};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_t || cmd.mul_av || cmd.mul_l || cmd.mul_r) prod <= mul_a * mul_b;
    if (cmd.mul_t) act_zero <= (cur_r >= range_cap) || (range_cap <= full_dist);
    if (cmd.mul_l) av <= prod[AV_W-1:0];
  end

  // accumulators; the right product lands in the cycle after the left one
  always_ff @(posedge clk) begin
    if (rst) begin
      r_pend <= 1'b0;
    end else begin
      r_pend <= cmd.mul_r;
    end
    if (cmd.accept) begin
      sum_l   <= '0;
      sum_r   <= '0;
      nearest <= '1;
    end else begin
      if (cmd.mul_r) sum_l <= sum_l + $signed(prod[ACC_W-1:0]);
      if (r_pend)    sum_r <= sum_r + $signed(prod[ACC_W-1:0]);
      if (cmd.mul_t && cur_r < nearest) nearest <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_left    <= finish(sum_l, speed_floor, speed_ceiling);
      out_right   <= finish(sum_r, speed_floor, speed_ceiling);
      out_nearest <= nearest;
    end
  end

  assign m_tdata = M_DATA_W'({out_nearest, out_right, out_left});

endmodule

`default_nettype wire

### rtl/core/braitenberg_wheel_speed.sv
// top level: eight-sensor repulsion controller giving two wheel speeds
// sequence: after accept each slot takes four products on one shared multiplier (T, AV,
// L, R phases), then FLUSH and DONE, where the result beat is loaded once the output is
// free; a new item is taken only in IDLE, and a held result beat does not block accept
// reset: synchronous rst clears the sequencer, sets registers to their reset values and
// fills every range slot with the reset max range at once
`default_nettype none

module braitenberg_wheel_speed (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bws_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bws_pkg::S_DATA_W-1:0]  s_tdata,  // sensor_index, range_reading, zero pad
  input  logic                          s_tuser,  // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bws_pkg::M_DATA_W-1:0]  m_tdata   // left_speed, right_speed, nearest_range
);
  import bws_pkg::*;

  bws_cmd_t cmd;

  bws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  bws_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (s_tuser),
    .sensor_index  (s_tdata[IDX_W-1:0]),
    .range_reading (s_tdata[IDX_W +: RANGE_W]),
    .cmd           (cmd),
    .m_tdata       (m_tdata)
  );

endmodule

`default_nettype wire

### rtl/core/bws_checker.sv
// port-level checks for the wheel speed controller, bound to the top level
`default_nettype none

module bws_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [bws_pkg::M_DATA_W-1:0]  m_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // one item at a time: input closes right after an accepted beat
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still open after accept");

  // a new result only appears while the block is busy
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result beat without a pending item");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind braitenberg_wheel_speed bws_checker u_checker (.*);

`default_nettype wire

### tb/sv/tb.sv
// self-checking stream testbench for the braitenberg wheel speed controller
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bws_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] slot;
    logic [15:0]      reading;
  } sensor_event_t;

  typedef struct packed {
    logic [15:0]        nearest;
    logic signed [15:0] right;
    logic signed [15:0] left;
  } wheel_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;

  braitenberg_wheel_speed dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // controller copy: registers and range slots
  logic [PACKED_W-1:0] left_w;
  logic [PACKED_W-1:0] right_w;
  logic [15:0]         v0;
  logic signed [15:0]  speed_lo;
  logic signed [15:0]  speed_hi;
  logic [15:0]         range_cap;
  logic [15:0]         full_dist;
  logic [15:0]         inv_span;
  logic [15:0]         ranges [NUM_SENSORS];

  sensor_event_t pending_events[$];
  wheel_cmd_t    expected_speeds[$];
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            fail_count = 0;
  int            cycle_count = 0;

  function automatic logic [16:0] activation_of(logic [15:0] r);
    logic [15:0]     d;
    longint unsigned t;
    if (r >= range_cap || range_cap <= full_dist) return '0;
    d = (r < full_dist) ? full_dist : r;
    t = ((64'(d) - 64'(full_dist)) * 64'(inv_span) + 64'd128) >> 8;
    if (t >= 64'(ACT_ONE)) return '0;
    return 17'(64'(ACT_ONE) - t);
  endfunction

  function automatic logic [15:0] saturate_speed(longint sum);
    longint v;
    v = (sum + 64'sd524288) >>> FRAC_DROP;
    if (v < longint'(speed_lo)) v = longint'(speed_lo);
    if (v > longint'(speed_hi)) v = longint'(speed_hi);
    return v[15:0];
  endfunction

  function automatic wheel_cmd_t steer(sensor_event_t ev);
    wheel_cmd_t  res;
    longint      sum_l;
    longint      sum_r;
    longint      av;
    logic [15:0] r;
    sum_l = 0;
    sum_r = 0;
    res.nearest = 16'hffff;
    if (ev.action) begin
      for (int k = 0; k < NUM_SENSORS; k++) ranges[k] = range_cap;
    end else if (int'(ev.slot) < NUM_SENSORS) begin
      r = (ev.reading < RANGE_FLOOR) ? RANGE_FLOOR : ev.reading;
      if (r > range_cap) r = range_cap;
      ranges[ev.slot] = r;
    end
    for (int k = 0; k < NUM_SENSORS; k++) begin
      av = longint'(activation_of(ranges[k])) * longint'(v0);
      if (k < NUM_WEIGHTS) begin
        sum_l += longint'($signed(left_w[8*k +: 8])) * av;
        sum_r += longint'($signed(right_w[8*k +: 8])) * av;
      end
      if (ranges[k] < res.nearest) res.nearest = ranges[k];
    end
    res.left  = saturate_speed(sum_l);
    res.right = saturate_speed(sum_r);
    return res;
  endfunction

  function automatic void model_reset();
    left_w    = '0;
    right_w   = '0;
    v0        = BASE_SPEED_RST;
    speed_lo  = FLOOR_RST;
    speed_hi  = CEILING_RST;
    range_cap = MAX_RANGE_RST;
    full_dist = FULL_DIST_RST;
    inv_span  = INV_SPAN_RST;
    for (int k = 0; k < NUM_SENSORS; k++) ranges[k] = MAX_RANGE_RST;
  endfunction

  function automatic void model_write(bws_reg_t idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_LEFT_W:    left_w = val;
      REG_RIGHT_W:   right_w = val;
      REG_BASE:      v0 = val[15:0];
      REG_FLOOR:     speed_lo = val[15:0];
      REG_CEILING:   speed_hi = val[15:0];
      REG_MAX_RANGE: range_cap = val[15:0];
      REG_FULL_DIST: full_dist = val[15:0];
      REG_INV_SPAN:  inv_span = val[15:0];
      default: ;
    endcase
  endfunction

  // sender
  always @(posedge clk) begin : drive
    sensor_event_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_speeds.push_back(steer({s_tuser, s_tdata[IDX_W-1:0],
                                         s_tdata[IDX_W +: RANGE_W]}));
      if (!s_tvalid || s_tready) begin
        if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_events.pop_front();
          s_tdata  <= S_DATA_W'({nxt.reading, nxt.slot});
          s_tuser  <= nxt.action;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : watch
    wheel_cmd_t got;
    wheel_cmd_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_speeds.size() == 0) begin
          $error("result beat with nothing pending: %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_speeds.pop_front();
          if (got.left !== want.left) begin
            $error("left_speed expected %0d got %0d", want.left, got.left);
            fail_count++;
          end
          if (got.right !== want.right) begin
            $error("right_speed expected %0d got %0d", want.right, got.right);
            fail_count++;
          end
          if (got.nearest !== want.nearest) begin
            $error("nearest_range expected %0d got %0d", want.nearest, got.nearest);
            fail_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_quiet();
    @(negedge clk);
    while (pending_events.size() > 0 || s_tvalid || expected_speeds.size() > 0)
      @(negedge clk);
  endtask

  task automatic write_reg(bws_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    model_write(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(logic [63:0] lw, logic [63:0] rw, logic [15:0] base,
                               logic [15:0] lo, logic [15:0] hi, logic [15:0] maxr,
                               logic [15:0] fdist, logic [15:0] inv);
    write_reg(REG_LEFT_W, lw);
    write_reg(REG_RIGHT_W, rw);
    write_reg(REG_BASE, 64'(base));
    write_reg(REG_FLOOR, 64'(lo));
    write_reg(REG_CEILING, 64'(hi));
    write_reg(REG_MAX_RANGE, 64'(maxr));
    write_reg(REG_FULL_DIST, 64'(fdist));
    write_reg(REG_INV_SPAN, 64'(inv));
  endtask

  task automatic random_settings();
    logic [15:0] base;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] maxr;
    logic [15:0] fdist;
    logic [15:0] inv;
    int          span;
    case ($urandom_range(3))
      0: base = 16'd4096;
      1: base = 16'hffff;
      2: base = 16'($urandom_range(0, 8192));
      default: base = 16'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(5) == 0) begin
      lo = 16'($urandom_range(0, 65535));
      hi = 16'($urandom_range(0, 65535));
    end else begin
      lo = 16'(-$urandom_range(0, 32768));
      hi = 16'($urandom_range(0, 32767));
    end
    case ($urandom_range(7))
      0: maxr = 16'hffff;
      1: maxr = 16'($urandom_range(0, 90));
      default: maxr = 16'($urandom_range(1000, 8000));
    endcase
    fdist = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 65535))
                                     : 16'($urandom_range(0, maxr));
    span = int'(maxr) - int'(fdist);
    if (span > 0 && $urandom_range(3) != 0)
      inv = ((1 << 24) / span > 65535) ? 16'hffff : 16'((1 << 24) / span);
    else
      inv = 16'($urandom_range(0, 65535));
    load_settings({$urandom, $urandom}, {$urandom, $urandom}, base, lo, hi, maxr, fdist, inv);
  endtask

  task automatic add_event(logic action, int slot, int reading);
    sensor_event_t ev;
    ev.action  = action;
    ev.slot    = IDX_W'(slot);
    ev.reading = 16'(reading);
    pending_events.push_back(ev);
  endtask

  task automatic add_random_events(int n);
    int top;
    top = int'(range_cap) + int'(range_cap) / 8 + 1;
    if (top > 65535) top = 65535;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        add_event(1'b1, $urandom_range(7), $urandom_range(0, 65535));
      end else begin
        case ($urandom_range(9))
          0, 1: add_event(1'b0, $urandom_range(7), $urandom_range(0, 65535));
          2: add_event(1'b0, $urandom_range(7), $urandom_range(0, 100));
          default: add_event(1'b0, $urandom_range(7), $urandom_range(0, top));
        endcase
      end
    end
  endtask

  task automatic set_pace(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: clamping at both ends and the refill
    add_event(1'b0, 0, 0);
    add_event(1'b0, 1, 65535);
    add_event(1'b0, 2, 81);
    add_event(1'b0, 3, 82);
    add_event(1'b0, 4, 83);
    add_event(1'b0, 5, 410);
    add_event(1'b0, 6, 4095);
    add_event(1'b0, 7, 4096);
    add_event(1'b1, 7, 65535);
    wait_quiet();

    // extreme weights and speed scale, saturating both wheels
    load_settings(64'h7f7f7f7f7f7f7f7f, 64'h8080808080808080, 16'hffff,
                  16'h8000, 16'h7fff, 16'd4096, 16'd410, 16'd4551);
    add_event(1'b0, 0, 0);
    add_event(1'b0, 3, 409);
    add_event(1'b0, 7, 0);
    add_event(1'b1, 0, 0);
    wait_quiet();

    // floor above ceiling, max range below the range floor
    load_settings(64'h0180ff7f01807fff, 64'hff017f80ff01807f, 16'd4096,
                  16'd1000, 16'(-1000), 16'd50, 16'd60, 16'hffff);
    add_event(1'b0, 2, 0);
    add_event(1'b0, 5, 65535);
    wait_quiet();

    // activation underflow at a wide range, then stale slots under a lowered max
    load_settings(64'h7f7f7f7f7f7f7f7f, 64'h0102040810204080, 16'd4096,
                  16'h8000, 16'h7fff, 16'hffff, 16'd0, 16'hffff);
    add_event(1'b0, 1, 2000);
    add_event(1'b0, 4, 82);
    wait_quiet();
    write_reg(REG_MAX_RANGE, 64'd1000);
    write_reg(REG_INV_SPAN, 64'd28000);
    add_event(1'b0, 6, 500);
    wait_quiet();

    for (int p = 0; p < 8; p++) begin
      set_pace(p % 4);
      random_settings();
      if (p == 2) begin
        // sender holds off until the block has drained
        add_random_events(50);
        wait_quiet();
        add_random_events(55);
      end else begin
        add_random_events(105);
      end
      wait_quiet();
    end

    repeat (4 * NUM_SENSORS + 12) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### braitenberg_wheel_speed.f
rtl/core/bws_pkg.sv
rtl/core/bws_ctrl.sv
rtl/core/bws_datapath.sv
rtl/core/braitenberg_wheel_speed.sv
rtl/core/bws_checker.sv
tb/sv/tb.sv
